### rtl/core/ps2md_pkg.sv
// Shared types and constants for the PS/2 mouse packet decoder.
// No dependencies; used by every module of the block but the checker.
package ps2md_pkg;

    // Header bit positions
    localparam int unsigned SyncBit   = 3;
    localparam int unsigned SignXBit  = 4;
    localparam int unsigned SignYBit  = 5;
    localparam int unsigned OvfXBit   = 6;
    localparam int unsigned OvfYBit   = 7;

    // Wheel byte codes
    localparam logic [7:0] WHEEL_UP   = 8'h01;
    localparam logic [7:0] WHEEL_DOWN = 8'hFF;

    // Wheel step codes
    localparam logic signed [1:0] DZ_UP   = 2'sb01;
    localparam logic signed [1:0] DZ_DOWN = 2'sb11;
    localparam logic signed [1:0] DZ_NONE = 2'sb00;

    // Position of the next byte within a packet
    typedef enum logic [1:0] {
        POS_HDR   = 2'd0,
        POS_X     = 2'd1,
        POS_Y     = 2'd2,
        POS_WHEEL = 2'd3
    } pos_t;

    // Complete packet handed from the framer to the decoder
    typedef struct packed {
        logic       done;
        logic       use_wheel;
        logic [7:0] hdr;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] wheel;
    } packet_t;

    // Decoded result item
    typedef struct packed {
        logic signed [1:0] delta_wheel;
        logic signed [8:0] delta_y;
        logic signed [8:0] delta_x;
        logic        [1:0] buttons;
    } result_t;

endpackage

### rtl/core/ps2_mouse_packet_decoder_top.sv
// Top level of the PS/2 mouse packet decoder (3- or 4-byte packets).
// Depends on ps2md_pkg, ps2md_framer, ps2md_decode, ps2md_out_reg.
//
//  channel   dir  width  contents
//  s_axis    in   8      tdata[7:0] rx_byte
//  m_axis    out  24     tdata buttons, delta_x, delta_y, delta_wheel
//  cfg       in   1      cfg_wdata[0] wheel_mode, written when cfg_we
//
// One byte is taken every cycle while s_axis_tready is high; a result appears
// in the cycle after the byte that completes its packet, set by the single result register.
// s_axis_tready drops only while a result waits and m_axis_tready is low.
// Reset clears the byte position, the held result and wheel_mode.
module ps2_mouse_packet_decoder_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [1:0] buttons, [10:2] delta_x,
                                        // [19:11] delta_y, [21:20] delta_wheel
    input  logic        cfg_we,
    input  logic        cfg_wdata
);

    logic               wheel_mode_reg;
    logic               accept;
    ps2md_pkg::packet_t pkt;
    ps2md_pkg::result_t res;
    ps2md_pkg::result_t out_res;

    // Hold the wheel mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wheel_mode_reg <= 1'b0;
        else if (cfg_we)
            wheel_mode_reg <= cfg_wdata;
    end

    assign accept = s_axis_tvalid && s_axis_tready;

    ps2md_framer u_framer
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .rx_byte    (s_axis_tdata),
        .wheel_mode (wheel_mode_reg),
        .pkt        (pkt)
    );

    ps2md_decode u_decode
    (
        .pkt (pkt),
        .res (res)
    );

    ps2md_out_reg u_out_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (pkt.done),
        .res       (res),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_res   (out_res),
        .in_ready  (s_axis_tready)
    );

    // Pack the result, lowest field first
    assign m_axis_tdata = {2'b00, out_res.delta_wheel, out_res.delta_y,
                           out_res.delta_x, out_res.buttons};

endmodule

### rtl/core/ps2md_framer.sv
// Packet framer: tracks byte position and stores header, X and Y bytes.
// Depends on ps2md_pkg.
module ps2md_framer
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          rx_byte,
    input  logic                wheel_mode,
    output ps2md_pkg::packet_t  pkt
);

    ps2md_pkg::pos_t pos_reg;
    ps2md_pkg::pos_t pos_next;
    logic [7:0]      hdr_reg;
    logic [7:0]      x_reg;
    logic [7:0]      y_reg;

    // Advance the byte position; drop unsynchronized header bytes
    always_comb
    begin
        pos_next = pos_reg;
        if (accept)
        begin
            case (pos_reg)
                ps2md_pkg::POS_HDR:
                begin
                    if (rx_byte[ps2md_pkg::SyncBit])
                        pos_next = ps2md_pkg::POS_X;
                end
                ps2md_pkg::POS_X:
                    pos_next = ps2md_pkg::POS_Y;
                ps2md_pkg::POS_Y:
                    pos_next = wheel_mode ? ps2md_pkg::POS_WHEEL : ps2md_pkg::POS_HDR;
                ps2md_pkg::POS_WHEEL:
                    pos_next = ps2md_pkg::POS_HDR;
                default:
                    pos_next = ps2md_pkg::POS_HDR;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= ps2md_pkg::POS_HDR;
        else
            pos_reg <= pos_next;
    end

    // Capture packet bytes at their positions
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (pos_reg == ps2md_pkg::POS_HDR)
                hdr_reg <= rx_byte;
            if (pos_reg == ps2md_pkg::POS_X)
                x_reg <= rx_byte;
            if (pos_reg == ps2md_pkg::POS_Y)
                y_reg <= rx_byte;
        end
    end

    // Flag packet completion; Y comes straight from the bus on the third byte
    always_comb
    begin
        pkt.done      = 1'b0;
        pkt.use_wheel = 1'b0;
        pkt.hdr       = hdr_reg;
        pkt.x         = x_reg;
        pkt.y         = y_reg;
        pkt.wheel     = rx_byte;
        case (pos_reg)
            ps2md_pkg::POS_Y:
            begin
                pkt.done = accept && !wheel_mode;
                pkt.y    = rx_byte;
            end
            ps2md_pkg::POS_WHEEL:
            begin
                pkt.done      = accept;
                pkt.use_wheel = wheel_mode;
            end
            default:
            begin
                pkt.done = 1'b0;
            end
        endcase
    end

endmodule

### rtl/core/ps2md_decode.sv
// Packet decoder: builds buttons, signed X/Y movement and wheel step.
// Depends on ps2md_pkg.
module ps2md_decode
(
    input  ps2md_pkg::packet_t  pkt,
    output ps2md_pkg::result_t  res
);

    logic overflow;

    assign overflow = pkt.hdr[ps2md_pkg::OvfXBit] | pkt.hdr[ps2md_pkg::OvfYBit];

    // Attach header sign bits, zero movement on overflow; map the wheel byte to a step
    always_comb
    begin
        res.buttons = pkt.hdr[1:0];
        if (overflow)
        begin
            res.delta_x = '0;
            res.delta_y = '0;
        end
        else
        begin
            res.delta_x = {pkt.hdr[ps2md_pkg::SignXBit], pkt.x};
            res.delta_y = {pkt.hdr[ps2md_pkg::SignYBit], pkt.y};
        end

        // Any wheel code other than up or down gives no step
        res.delta_wheel = ps2md_pkg::DZ_NONE;
        if (pkt.use_wheel)
        begin
            if (pkt.wheel == ps2md_pkg::WHEEL_UP)
                res.delta_wheel = ps2md_pkg::DZ_UP;
            else if (pkt.wheel == ps2md_pkg::WHEEL_DOWN)
                res.delta_wheel = ps2md_pkg::DZ_DOWN;
        end
    end

endmodule

### rtl/core/ps2md_out_reg.sv
// Result register for the output stream; sets input readiness.
// Depends on ps2md_pkg.
module ps2md_out_reg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  ps2md_pkg::result_t  res,
    input  logic                out_ready,
    output logic                out_valid,
    output ps2md_pkg::result_t  out_res,
    output logic                in_ready
);

    logic               valid_reg;
    logic               valid_next;
    ps2md_pkg::result_t res_reg;

    // Accept a new item whenever the held result is empty or leaving
    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Hold the payload until replaced
    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

### rtl/core/ps2md_checker.sv
// Port-level checks for the PS/2 mouse packet decoder, bound to the top.
// Depends on ps2_mouse_packet_decoder_top ports only.
module ps2md_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    // Stalled result holds its payload
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // Input stalls only behind a waiting result
    a_ready_gap: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without a waiting result");

    // A taken result with no new item leaves the output empty
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !(s_axis_tvalid && s_axis_tready)
        |=> !m_axis_tvalid)
        else $error("result repeated without new input");

    // A result appears only after an accepted byte
    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
        else $error("result without input");

    // Wheel step is never the unused code, and the padding bits are zero
    a_wheel_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[21:20] != 2'b10 && m_axis_tdata[23:22] == 2'b00)
        else $error("bad wheel step or padding");

endmodule

bind ps2_mouse_packet_decoder_top ps2md_checker u_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
